>>> hw/rtl/aarm_pkg.sv
// Shared types, constants and rounding helpers for the axis-angle rotation matrix block.
package aarm_pkg;

	// Latency of the axis normalization pipeline, in register stages.
	localparam int unsigned NORM_LAT = 43;
	// Register stages for one series term.
	localparam int unsigned SER_STEP_LAT = 5;
	// One in Q.28.
	localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;

	typedef logic signed [15:0] comp_t;
	typedef comp_t [2:0] vec3_t;
	typedef logic signed [31:0] q28_t;

	typedef struct packed {
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [15:0] angle;
	} req_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
		logic zero_axis;
	} res_t;

	// Q.56 product back to Q.28, rounding to nearest with ties away from zero.
	function automatic logic signed [35:0] round_q28(input logic signed [63:0] p);
		logic [63:0] mag;
		logic [63:0] r;
		mag = p[63] ? 64'(-p) : 64'(p);
		r = (mag + (64'd1 << 27)) >> 28;
		round_q28 = p[63] ? -$signed(36'(r)) : $signed(36'(r));
	endfunction

	// Unit axis times sine, Q.42 down to Q.28 with ties away from zero.
	function automatic logic signed [31:0] round_b(input logic signed [47:0] p);
		logic [47:0] mag;
		logic [47:0] r;
		mag = p[47] ? 48'(-p) : 48'(p);
		r = (mag + (48'd1 << 13)) >> 14;
		round_b = p[47] ? -$signed(32'(r)) : $signed(32'(r));
	endfunction

	// Q.56 matrix sum to a saturated Q2.14 entry, ties away from zero.
	function automatic logic signed [15:0] res_entry(input logic signed [63:0] v);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? 64'(-v) : 64'(v);
		r = (mag + (64'd1 << 41)) >> 42;
		if (!v[63]) begin
			res_entry = (r > 64'd32767) ? 16'sh7fff : $signed(16'(r));
		end else begin
			res_entry = (r > 64'd32768) ? 16'sh8000 : 16'(-$signed(17'(r)));
		end
	endfunction

endpackage

>>> hw/rtl/aarm_series.sv
// Pipelined truncated Taylor series for sine or cosine of the half angle in Q.28.
module aarm_series #(
	parameter int unsigned TERMS = 4,
	parameter bit ODD = 1'b1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  aarm_pkg::q28_t     first,
	input  logic [30:0]        x2,
	output logic               out_v,
	output aarm_pkg::q28_t     sum
);

	// Chain between term steps; index 0 is the input.
	logic           v_c    [0:TERMS-1];
	aarm_pkg::q28_t term_c [0:TERMS-1];
	aarm_pkg::q28_t sum_c  [0:TERMS-1];
	logic [30:0]    x2_c   [0:TERMS-1];

	assign v_c[0]    = in_v;
	assign term_c[0] = first;
	assign sum_c[0]  = first;
	assign x2_c[0]   = x2;

	for (genvar i = 1; i < TERMS; i++) begin : g_step
		localparam int unsigned K = ODD ? (2*i) * (2*i+1) : (2*i-1) * (2*i);
		localparam logic [7:0]  K8 = 8'(K);
		localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);
		localparam logic [31:0] HALF_K = 32'(K / 2);

		logic v_s1, v_s2, v_s3, v_s4, v_s5;
		logic signed [63:0] prod_s1;
		logic [31:0] n_s2, n_s3, n_s4;
		logic neg_s2, neg_s3, neg_s4;
		logic [63:0] pm_s3;
		logic [31:0] qe_s4;
		logic [39:0] qk_s4;
		aarm_pkg::q28_t term_s5;
		aarm_pkg::q28_t sum_s1, sum_s2, sum_s3, sum_s4, sum_s5;
		logic [30:0] x2_s1, x2_s2, x2_s3, x2_s4, x2_s5;

		logic signed [31:0] nx2;
		logic signed [35:0] qr;
		logic [35:0] qmag;
		logic [31:0] rem;
		logic [31:0] qf;
		aarm_pkg::q28_t term_n;

		// Previous term times minus x squared.
		assign nx2 = -$signed({1'b0, x2_c[i-1]});

		// Round the product and set up the rounded division by K.
		always_comb begin
			qr   = aarm_pkg::round_q28(prod_s1);
			qmag = qr[35] ? 36'(-qr) : 36'(qr);
		end

		// Reciprocal estimate is low by at most one; one correction step finishes it.
		always_comb begin
			rem    = n_s4 - qk_s4[31:0];
			qf     = (rem >= 32'(K)) ? qe_s4 + 32'd1 : qe_s4;
			term_n = neg_s4 ? -$signed(qf) : $signed(qf);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
				v_s3 <= 1'b0;
				v_s4 <= 1'b0;
				v_s5 <= 1'b0;
			end else if (en) begin
				v_s1 <= v_c[i-1];
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1 <= $signed(term_c[i-1]) * nx2;
				sum_s1  <= sum_c[i-1];
				x2_s1   <= x2_c[i-1];

				n_s2   <= qmag[31:0] + HALF_K;
				neg_s2 <= qr[35];
				sum_s2 <= sum_s1;
				x2_s2  <= x2_s1;

				pm_s3  <= n_s2 * RECIP;
				n_s3   <= n_s2;
				neg_s3 <= neg_s2;
				sum_s3 <= sum_s2;
				x2_s3  <= x2_s2;

				qe_s4  <= pm_s3[63:32];
				qk_s4  <= pm_s3[63:32] * K8;
				n_s4   <= n_s3;
				neg_s4 <= neg_s3;
				sum_s4 <= sum_s3;
				x2_s4  <= x2_s3;

				term_s5 <= term_n;
				sum_s5  <= sum_s4 + term_n;
				x2_s5   <= x2_s4;
			end
		end

		assign v_c[i]    = v_s5;
		assign term_c[i] = term_s5;
		assign sum_c[i]  = sum_s5;
		assign x2_c[i]   = x2_s5;
	end

	assign out_v = v_c[TERMS-1];
	assign sum   = sum_c[TERMS-1];

endmodule

>>> hw/rtl/aarm_norm.sv
// Pipelined axis normalization: sum of squares, square root, and three rounded divisions.
module aarm_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  aarm_pkg::vec3_t axis,
	output logic            out_v,
	output logic            zero,
	output aarm_pkg::vec3_t unit
);

	localparam int unsigned ROOT_W = 24;
	localparam int unsigned QUO_W  = 15;

	logic v_s1, v_s2;
	logic [31:0] sq_s1 [0:2];
	aarm_pkg::vec3_t ax_s1, ax_s2;
	logic [31:0] s_s2;
	logic zero_s2;

	// Squares of the three components, then their sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				sq_s1[j] <= 32'($signed(axis[j]) * $signed(axis[j]));
			end
			ax_s1   <= axis;
			s_s2    <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			zero_s2 <= (sq_s1[0] | sq_s1[1] | sq_s1[2]) == 32'd0;
			ax_s2   <= ax_s1;
		end
	end

	// Integer square root of the sum shifted up by 16, one root bit per stage.
	logic [ROOT_W-1:0] sq_root_c [0:ROOT_W];
	logic [ROOT_W:0]   sq_rem_c  [0:ROOT_W];
	logic [31:0]       sq_s_c    [0:ROOT_W];
	aarm_pkg::vec3_t   sq_ax_c   [0:ROOT_W];
	logic              sq_zero_c [0:ROOT_W];
	logic              sq_v_c    [0:ROOT_W];

	assign sq_root_c[0] = '0;
	assign sq_rem_c[0]  = '0;
	assign sq_s_c[0]    = s_s2;
	assign sq_ax_c[0]   = ax_s2;
	assign sq_zero_c[0] = zero_s2;
	assign sq_v_c[0]    = v_s2;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		localparam int unsigned BI = ROOT_W - 1 - k;
		logic [47:0] rad;
		logic [ROOT_W+2:0] remx;
		logic [ROOT_W+2:0] trial;
		logic ge;
		logic v_sk, zero_sk;
		logic [ROOT_W-1:0] root_sk;
		logic [ROOT_W:0] rem_sk;
		logic [31:0] s_sk;
		aarm_pkg::vec3_t ax_sk;

		assign rad   = {sq_s_c[k], 16'h0000};
		assign remx  = {sq_rem_c[k], rad[2*BI+1 -: 2]};
		assign trial = {1'b0, sq_root_c[k], 2'b01};
		assign ge    = remx >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk <= 1'b0;
			end else if (en) begin
				v_sk <= sq_v_c[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_sk <= {sq_root_c[k][ROOT_W-2:0], ge};
				rem_sk  <= ge ? (ROOT_W+1)'(remx - trial) : remx[ROOT_W:0];
				s_sk    <= sq_s_c[k];
				ax_sk   <= sq_ax_c[k];
				zero_sk <= sq_zero_c[k];
			end
		end

		assign sq_root_c[k+1] = root_sk;
		assign sq_rem_c[k+1]  = rem_sk;
		assign sq_s_c[k+1]    = s_sk;
		assign sq_ax_c[k+1]   = ax_sk;
		assign sq_zero_c[k+1] = zero_sk;
		assign sq_v_c[k+1]    = v_sk;
	end

	// Numerators for the rounded division: |axis| * 2^22 + floor(r / 2).
	logic v_sn, zero_sn;
	logic [ROOT_W-1:0] r_sn;
	logic [37:0] num_sn [0:2];
	logic neg_sn [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else if (en) begin
			v_sn <= sq_v_c[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_sn    <= sq_root_c[ROOT_W];
			zero_sn <= sq_zero_c[ROOT_W];
			for (int j = 0; j < 3; j++) begin
				num_sn[j] <= {(sq_ax_c[ROOT_W][j][15] ? 16'(-sq_ax_c[ROOT_W][j])
					: 16'(sq_ax_c[ROOT_W][j])), 22'd0} + 38'(sq_root_c[ROOT_W] >> 1);
				neg_sn[j] <= sq_ax_c[ROOT_W][j][15];
			end
		end
	end

	// Restoring division, one quotient bit per stage in each of three lanes.
	logic [ROOT_W-1:0] dv_rem_c  [0:QUO_W][0:2];
	logic [QUO_W-1:0]  dv_quo_c  [0:QUO_W][0:2];
	logic [37:0]       dv_num_c  [0:QUO_W][0:2];
	logic              dv_neg_c  [0:QUO_W][0:2];
	logic [ROOT_W-1:0] dv_r_c    [0:QUO_W];
	logic              dv_zero_c [0:QUO_W];
	logic              dv_v_c    [0:QUO_W];

	assign dv_r_c[0]    = r_sn;
	assign dv_zero_c[0] = zero_sn;
	assign dv_v_c[0]    = v_sn;

	for (genvar j = 0; j < 3; j++) begin : g_init
		assign dv_rem_c[0][j] = ROOT_W'(num_sn[j][37:QUO_W]);
		assign dv_quo_c[0][j] = '0;
		assign dv_num_c[0][j] = num_sn[j];
		assign dv_neg_c[0][j] = neg_sn[j];
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		localparam int unsigned BI = QUO_W - 1 - k;
		logic v_sk, zero_sk;
		logic [ROOT_W-1:0] r_sk;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk <= 1'b0;
			end else if (en) begin
				v_sk <= dv_v_c[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_sk    <= dv_r_c[k];
				zero_sk <= dv_zero_c[k];
			end
		end

		assign dv_r_c[k+1]    = r_sk;
		assign dv_zero_c[k+1] = zero_sk;
		assign dv_v_c[k+1]    = v_sk;

		for (genvar j = 0; j < 3; j++) begin : g_lane
			logic [ROOT_W:0] remx;
			logic ge;
			logic [ROOT_W-1:0] rem_sk;
			logic [QUO_W-1:0] quo_sk;
			logic [37:0] num_sk;
			logic neg_sk;

			assign remx = {dv_rem_c[k][j], dv_num_c[k][j][BI]};
			assign ge   = remx >= {1'b0, dv_r_c[k]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_sk <= ge ? ROOT_W'(remx - {1'b0, dv_r_c[k]}) : remx[ROOT_W-1:0];
					quo_sk <= {dv_quo_c[k][j][QUO_W-2:0], ge};
					num_sk <= dv_num_c[k][j];
					neg_sk <= dv_neg_c[k][j];
				end
			end

			assign dv_rem_c[k+1][j] = rem_sk;
			assign dv_quo_c[k+1][j] = quo_sk;
			assign dv_num_c[k+1][j] = num_sk;
			assign dv_neg_c[k+1][j] = neg_sk;
		end
	end

	// Restore the component signs.
	logic v_so, zero_so;
	aarm_pkg::vec3_t unit_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_so <= 1'b0;
		end else if (en) begin
			v_so <= dv_v_c[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_so <= dv_zero_c[QUO_W];
			for (int j = 0; j < 3; j++) begin
				unit_so[j] <= dv_neg_c[QUO_W][j] ? -$signed(16'(dv_quo_c[QUO_W][j]))
					: $signed(16'(dv_quo_c[QUO_W][j]));
			end
		end
	end

	assign out_v = v_so;
	assign zero  = zero_so;
	assign unit  = unit_so;

endmodule

>>> hw/rtl/axis_angle_rotation_matrix.sv
// Top level: axis-angle request to Euler-Rodrigues rotation matrix, fully pipelined.
//
// Each request carries an axis (Q4.12) and an angle (Q3.13) and yields one result of nine
// Q2.14 matrix entries plus a zero-axis flag. One request is accepted every cycle while
// req_stall is low. The latency is set by the axis normalization path, a 24-stage square
// root followed by a 15-stage divider; the sine and cosine series (five stages per term)
// are padded to match, so the latency does not change with SERIES_TERMS. A skid register
// behind the output lets one more request in while a result waits; req_stall rises only
// when that register is full.
module axis_angle_rotation_matrix #(
	parameter int unsigned SERIES_TERMS = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  aarm_pkg::req_t  req_data,
	output logic            res_valid,
	input  logic            res_stall,
	output aarm_pkg::res_t  res_data
);

	localparam int unsigned DLY = aarm_pkg::NORM_LAT - 1
		- aarm_pkg::SER_STEP_LAT * (SERIES_TERMS - 1);

	logic en;
	logic skid_valid_q, res_valid_q;
	aarm_pkg::res_t skid_q, res_q;

	// The whole pipeline moves unless the skid register holds a result.
	assign en        = !skid_valid_q;
	assign req_stall = skid_valid_q;

	// Request register and series setup.
	logic v_s1, v_s2;
	aarm_pkg::req_t req_s1;
	logic [30:0] x2_s2;
	aarm_pkg::q28_t first_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
		end
	end

	// The half angle in Q.28 is angle * 2^14, so its square in Q.28 is angle squared.
	always_ff @(posedge clk) begin
		if (en) begin
			req_s1   <= req_data;
			x2_s2    <= 31'(32'($signed(req_s1.angle) * $signed(req_s1.angle)));
			first_s2 <= $signed(32'(req_s1.angle)) <<< 14;
		end
	end

	// Unit axis.
	logic norm_v, norm_zero;
	aarm_pkg::vec3_t norm_unit;

	aarm_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s1),
		.axis   ({req_s1.axis_z, req_s1.axis_y, req_s1.axis_x}),
		.out_v  (norm_v),
		.zero   (norm_zero),
		.unit   (norm_unit)
	);

	// Sine and cosine of the half angle.
	logic sin_v, cos_v;
	aarm_pkg::q28_t sin_sum, cos_sum;

	aarm_series #(.TERMS(SERIES_TERMS), .ODD(1'b1)) u_sin (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s2),
		.first  (first_s2),
		.x2     (x2_s2),
		.out_v  (sin_v),
		.sum    (sin_sum)
	);

	aarm_series #(.TERMS(SERIES_TERMS), .ODD(1'b0)) u_cos (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s2),
		.first  (aarm_pkg::ONE_Q28),
		.x2     (x2_s2),
		.out_v  (cos_v),
		.sum    (cos_sum)
	);

	// Delay line that lines the series results up with the unit axis.
	logic           dl_v  [0:DLY];
	aarm_pkg::q28_t dl_sn [0:DLY];
	aarm_pkg::q28_t dl_a  [0:DLY];

	assign dl_v[0]  = sin_v & cos_v;
	assign dl_sn[0] = sin_sum;
	assign dl_a[0]  = cos_sum;

	for (genvar k = 1; k <= DLY; k++) begin : g_dly
		logic v_sk;
		aarm_pkg::q28_t sn_sk, a_sk;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk <= 1'b0;
			end else if (en) begin
				v_sk <= dl_v[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sn_sk <= dl_sn[k-1];
				a_sk  <= dl_a[k-1];
			end
		end

		assign dl_v[k]  = v_sk;
		assign dl_sn[k] = sn_sk;
		assign dl_a[k]  = a_sk;
	end

	// Quaternion parts b, c, d, the ten products, the nine sums and the output entries.
	logic v_s3, v_s4, v_s5, v_s6, v_s7;
	logic zero_s3, zero_s4, zero_s5, zero_s6;
	aarm_pkg::q28_t a_s3, a_s4;
	logic signed [47:0] pb_s3 [0:2];
	aarm_pkg::q28_t bcd_s4 [0:2];
	logic signed [63:0] aa_s5, bb_s5, cc_s5, dd_s5, ab_s5, ac_s5, ad_s5, bc_s5, bd_s5, cd_s5;
	logic signed [63:0] sum_s6 [0:8];
	aarm_pkg::res_t res_s7;
	aarm_pkg::res_t res_n;

	always_comb begin
		if (zero_s6) begin
			res_n = '0;
			res_n.zero_axis = 1'b1;
		end else begin
			res_n.m00 = aarm_pkg::res_entry(sum_s6[0]);
			res_n.m01 = aarm_pkg::res_entry(sum_s6[1]);
			res_n.m02 = aarm_pkg::res_entry(sum_s6[2]);
			res_n.m10 = aarm_pkg::res_entry(sum_s6[3]);
			res_n.m11 = aarm_pkg::res_entry(sum_s6[4]);
			res_n.m12 = aarm_pkg::res_entry(sum_s6[5]);
			res_n.m20 = aarm_pkg::res_entry(sum_s6[6]);
			res_n.m21 = aarm_pkg::res_entry(sum_s6[7]);
			res_n.m22 = aarm_pkg::res_entry(sum_s6[8]);
			res_n.zero_axis = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s3 <= norm_v;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				pb_s3[j]  <= -($signed(norm_unit[j]) * $signed(dl_sn[DLY]));
				bcd_s4[j] <= aarm_pkg::round_b(pb_s3[j]);
			end
			a_s3    <= dl_a[DLY];
			zero_s3 <= norm_zero;
			a_s4    <= a_s3;
			zero_s4 <= zero_s3;

			aa_s5 <= a_s4 * a_s4;
			bb_s5 <= bcd_s4[0] * bcd_s4[0];
			cc_s5 <= bcd_s4[1] * bcd_s4[1];
			dd_s5 <= bcd_s4[2] * bcd_s4[2];
			ab_s5 <= a_s4 * bcd_s4[0];
			ac_s5 <= a_s4 * bcd_s4[1];
			ad_s5 <= a_s4 * bcd_s4[2];
			bc_s5 <= bcd_s4[0] * bcd_s4[1];
			bd_s5 <= bcd_s4[0] * bcd_s4[2];
			cd_s5 <= bcd_s4[1] * bcd_s4[2];
			zero_s5 <= zero_s4;

			sum_s6[0] <= aa_s5 + bb_s5 - cc_s5 - dd_s5;
			sum_s6[1] <= (bc_s5 + ad_s5) <<< 1;
			sum_s6[2] <= (bd_s5 - ac_s5) <<< 1;
			sum_s6[3] <= (bc_s5 - ad_s5) <<< 1;
			sum_s6[4] <= aa_s5 - bb_s5 + cc_s5 - dd_s5;
			sum_s6[5] <= (cd_s5 + ab_s5) <<< 1;
			sum_s6[6] <= (bd_s5 + ac_s5) <<< 1;
			sum_s6[7] <= (cd_s5 - ab_s5) <<< 1;
			sum_s6[8] <= aa_s5 - bb_s5 - cc_s5 + dd_s5;
			zero_s6   <= zero_s5;

			res_s7 <= res_n;
		end
	end

	// Output register with a skid register behind it.
	logic res_room;
	assign res_room = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res_room) begin
			res_valid_q  <= skid_valid_q || v_s7;
			skid_valid_q <= 1'b0;
		end else if (en && v_s7) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_room) begin
			res_q <= skid_valid_q ? skid_q : res_s7;
		end else if (en && v_s7) begin
			skid_q <= res_s7;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// The padded series path must arrive together with the unit axis.
	a_align: assert property (@(posedge clk) disable iff (!arst_n) norm_v == dl_v[DLY])
		else $error("series and normalization paths out of step");

	// The skid register only fills behind a held output.
	a_skid_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid register full while output is empty");

	a_skid_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(res_valid_q && res_stall))
		else $error("skid register loaded without a stalled output");

endmodule

>>> verif/axis_angle_rotation_matrix_tb.sv
// Testbench for axis_angle_rotation_matrix: directed and random requests checked against a predictor.
module axis_angle_rotation_matrix_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TERMS = 4;
	localparam int FRAC = 28;
	localparam int OUT_SH = 42;
	localparam int LATENCY = 49;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_REQUESTS = 1850;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	aarm_pkg::req_t req_data;
	logic res_valid;
	logic res_stall;
	aarm_pkg::res_t res_data;

	aarm_pkg::res_t expected_matrices[$];
	int errors;
	int idle_cycles;
	bit steady;

	axis_angle_rotation_matrix #(.SERIES_TERMS(TERMS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Shift right with rounding to nearest, ties away from zero.
	function automatic longint shift_round(longint v, int n);
		longint half;
		half = 64'sd1 <<< (n - 1);
		if (v >= 0) begin
			return (v + half) >>> n;
		end
		return -((-v + half) >>> n);
	endfunction

	// Division with rounding to nearest, ties away from zero.
	function automatic longint div_nearest(longint v, longint k);
		if (v >= 0) begin
			return (v + k / 2) / k;
		end
		return -((-v + k / 2) / k);
	endfunction

	// Integer square root, rounded down.
	function automatic longint floor_sqrt(longint v);
		longint root;
		longint bitv;
		root = 0;
		bitv = 64'sd1 <<< 62;
		while (bitv > v) bitv = bitv >>> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >>> 1) + bitv;
			end else begin
				root = root >>> 1;
			end
			bitv = bitv >>> 2;
		end
		return root;
	endfunction

	// Truncated Taylor series in Q.28; odd selects the sine denominators.
	function automatic longint taylor_sum(longint first, longint x2, bit odd);
		longint term;
		longint sum;
		longint k;
		term = first;
		sum = first;
		for (int i = 1; i < TERMS; i++) begin
			k = odd ? longint'(2 * i) * (2 * i + 1) : longint'(2 * i - 1) * (2 * i);
			term = div_nearest(shift_round(term * -x2, FRAC), k);
			sum += term;
		end
		return sum;
	endfunction

	// Q.56 sum to a saturated Q2.14 entry.
	function automatic logic signed [15:0] to_entry(longint q56);
		longint v;
		v = shift_round(q56, OUT_SH);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	// Expected rotation matrix for one request.
	function automatic aarm_pkg::res_t rotation_for(aarm_pkg::req_t r);
		aarm_pkg::res_t m;
		longint axis[3];
		longint unit[3];
		longint q[3];
		longint sq, root, x, x2, sn, a, b, c, d;
		axis[0] = r.axis_x;
		axis[1] = r.axis_y;
		axis[2] = r.axis_z;
		m = '0;
		sq = axis[0] * axis[0] + axis[1] * axis[1] + axis[2] * axis[2];
		if (sq == 0) begin
			m.zero_axis = 1'b1;
			return m;
		end
		root = floor_sqrt(sq <<< 16);
		x = longint'(r.angle) * (64'sd1 <<< 14);
		x2 = shift_round(x * x, FRAC);
		sn = taylor_sum(x, x2, 1'b1);
		a = taylor_sum(64'sd1 <<< FRAC, x2, 1'b0);
		for (int j = 0; j < 3; j++) begin
			unit[j] = div_nearest(axis[j] * (64'sd1 <<< 22), root);
			q[j] = shift_round(-unit[j] * sn, 14);
		end
		b = q[0];
		c = q[1];
		d = q[2];
		m.m00 = to_entry(a * a + b * b - c * c - d * d);
		m.m01 = to_entry(2 * (b * c + a * d));
		m.m02 = to_entry(2 * (b * d - a * c));
		m.m10 = to_entry(2 * (b * c - a * d));
		m.m11 = to_entry(a * a - b * b + c * c - d * d);
		m.m12 = to_entry(2 * (c * d + a * b));
		m.m20 = to_entry(2 * (b * d + a * c));
		m.m21 = to_entry(2 * (c * d - a * b));
		m.m22 = to_entry(a * a - b * b - c * c + d * d);
		return m;
	endfunction

	// Random idle length: mostly none or short, a few long.
	function automatic int idle_length();
		int p;
		if (steady) begin
			return 0;
		end
		p = $urandom_range(99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// Send one request, wait for acceptance, then maybe idle.
	task automatic send_request(aarm_pkg::req_t r);
		int gap;
		req_data <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		expected_matrices.push_back(rotation_for(r));
		gap = idle_length();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic aarm_pkg::req_t make_request(int x, int y, int z, int ang);
		aarm_pkg::req_t r;
		r.axis_x = 16'(x);
		r.axis_y = 16'(y);
		r.axis_z = 16'(z);
		r.angle = 16'(ang);
		return r;
	endfunction

	// Extremes of every field, unit axes and the zero-length axis.
	task automatic test_directed();
		int angles[6] = '{0, 32767, -32768, 8192, -8192, 1};
		send_request(make_request(0, 0, 0, 12345));
		send_request(make_request(0, 0, 0, -32768));
		foreach (angles[i]) send_request(make_request(4096, 0, 0, angles[i]));
		send_request(make_request(0, 4096, 0, 12868));
		send_request(make_request(0, 0, -4096, -12868));
		send_request(make_request(32767, 32767, 32767, 32767));
		send_request(make_request(-32768, -32768, -32768, -32768));
		send_request(make_request(-32768, 32767, 0, 32767));
		send_request(make_request(1, 0, 0, 25736));
		send_request(make_request(0, 0, -1, -25736));
		send_request(make_request(1, -1, 1, 16384));
		send_request(make_request(32767, 0, 0, -32768));
		send_request(make_request(0, -32768, 0, 32767));
	endtask

	// Random requests: full-range, small, single-axis and zero axes.
	task automatic test_random();
		int kind;
		aarm_pkg::req_t r;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 150 == 0) steady = ($urandom_range(3) == 0);
			kind = $urandom_range(9);
			r = aarm_pkg::req_t'({$urandom, $urandom});
			case (kind)
				0: begin
					r.axis_x = '0;
					r.axis_y = '0;
					r.axis_z = '0;
				end
				1, 2: begin
					r.axis_x = 16'($urandom_range(15)) - 16'sd8;
					r.axis_y = 16'($urandom_range(15)) - 16'sd8;
					r.axis_z = 16'($urandom_range(15)) - 16'sd8;
				end
				3: begin
					r.axis_y = '0;
					r.axis_z = '0;
				end
				default: begin
				end
			endcase
			send_request(r);
		end
		steady = 1'b0;
		req_valid <= 1'b0;
	endtask

	// Result receiver stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= steady ? 1'b0 : ($urandom_range(99) < 25);
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		aarm_pkg::res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_matrices.size() == 0) begin
				errors++;
				$display("unexpected result at %0t", $realtime);
			end else begin
				want = expected_matrices.pop_front();
				for (int i = 0; i < 9; i++) begin
					if (res_data[144 - 16 * i -: 16] !== want[144 - 16 * i -: 16]) begin
						report($sformatf("entry %0d", i),
							$signed(res_data[144 - 16 * i -: 16]),
							$signed(want[144 - 16 * i -: 16]));
					end
				end
				if (res_data.zero_axis !== want.zero_axis) begin
					report("zero_axis", res_data.zero_axis, want.zero_axis);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted transfer.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("axis_angle_rotation_matrix regression: fail");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		wait (expected_matrices.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_matrices.size() == 0) begin
			$display("axis_angle_rotation_matrix regression: pass");
		end else begin
			$display("axis_angle_rotation_matrix regression: fail");
		end
		$finish;
	end
endmodule
